FILE: design/tdms_pkg.sv
// Shared types, constants and the decode function of the melody sequencer.
`default_nettype none

package tdms_pkg;

	// Store and counter geometry
	localparam int NOTE_DEPTH_DEF = 64;
	localparam int NOTE_W         = 16;
	localparam int IDX_W          = 7;
	localparam int IDX_SPAN       = 1 << IDX_W;
	localparam int COUNT_W        = 24;
	localparam int RATE_W         = 16;
	localparam int BR_W           = 12;
	localparam int RHS_W          = BR_W + RATE_W;
	localparam int LHS_W          = COUNT_W + 10;
	localparam int PERIOD_W       = 20;
	localparam int COMPARE_W      = 19;

	localparam logic [RATE_W-1:0]   TICK_RATE_RST = RATE_W'(100);
	localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;
	localparam logic [LHS_W-1:0]    MS_PER_S      = LHS_W'(1000);
	localparam int                  TIMER_CLK_HZ  = 1000000;
	localparam logic [PERIOD_W-1:0] SILENT_PERIOD = PERIOD_W'(TIMER_CLK_HZ / 1 - 1);

	// Request type codes
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic [4:0] tens;
		logic [3:0] units;
	} digits_t;

	// Beat lengths in milliseconds
	localparam logic [7:0] BEAT_MS [7] = '{
		8'd0, 8'd62, 8'd94, 8'd125, 8'd125, 8'd187, 8'd250
	};

	// Timer periods per {octave, step}; step zero is silence
	localparam logic [PERIOD_W-1:0] PERIOD_TAB [24] = '{
		SILENT_PERIOD,
		PERIOD_W'(TIMER_CLK_HZ / 261 - 1),  PERIOD_W'(TIMER_CLK_HZ / 293 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 329 - 1),  PERIOD_W'(TIMER_CLK_HZ / 349 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 391 - 1),  PERIOD_W'(TIMER_CLK_HZ / 440 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 493 - 1),
		SILENT_PERIOD,
		PERIOD_W'(TIMER_CLK_HZ / 523 - 1),  PERIOD_W'(TIMER_CLK_HZ / 587 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 659 - 1),  PERIOD_W'(TIMER_CLK_HZ / 698 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 783 - 1),  PERIOD_W'(TIMER_CLK_HZ / 880 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 987 - 1),
		SILENT_PERIOD,
		PERIOD_W'(TIMER_CLK_HZ / 1046 - 1), PERIOD_W'(TIMER_CLK_HZ / 1174 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 1318 - 1), PERIOD_W'(TIMER_CLK_HZ / 1396 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 1567 - 1), PERIOD_W'(TIMER_CLK_HZ / 1760 - 1),
		PERIOD_W'(TIMER_CLK_HZ / 1975 - 1)
	};

	// Split a byte into decimal tens and units (x*205>>11 is exact below 1029)
	function automatic digits_t split_digits(input logic [7:0] code);
		logic [15:0] prod;
		logic [7:0]  tens_x10;
		digits_t     d;
		prod     = 16'(code) * 16'd205;
		d.tens   = prod[15:11];
		tens_x10 = 8'(d.tens) * 8'd10;
		d.units  = 4'(code - tens_x10);
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: design/tdms_if.sv
// Request and result channel interfaces of the melody sequencer.
`default_nettype none

interface tdms_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [5:0] note_addr;
	logic [7:0] pitch_code;
	logic [7:0] duration_code;
	logic       play_enable;
	logic [5:0] first_note;
	logic [5:0] last_note;

	modport source (
		output valid, req_type, note_addr, pitch_code, duration_code,
		       play_enable, first_note, last_note,
		input  ready
	);
	modport sink (
		input  valid, req_type, note_addr, pitch_code, duration_code,
		       play_enable, first_note, last_note,
		output ready
	);
endinterface

interface tdms_rsp_if;
	logic        valid;
	logic        ready;
	logic        tone_write;
	logic [19:0] timer_period;
	logic [18:0] timer_compare;
	logic        playing;

	modport source (
		output valid, tone_write, timer_period, timer_compare, playing,
		input  ready
	);
	modport sink (
		input  valid, tone_write, timer_period, timer_compare, playing,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/tdms_note_mem.sv
// Note store: single-port-write, registered-read memory of note entries.
`default_nettype none

module tdms_note_mem #(
	parameter int NOTE_DEPTH = 64,
	localparam int AW = $clog2(NOTE_DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [tdms_pkg::NOTE_W-1:0] wdata,
	input  wire logic [AW-1:0]               raddr,
	output logic      [tdms_pkg::NOTE_W-1:0] rdata
);
	import tdms_pkg::*;

	logic [NOTE_W-1:0] mem_q [NOTE_DEPTH];
	logic [NOTE_W-1:0] rdata_q;

	// Write one entry, read one entry through a registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/tdms_player.sv
// Playback sequencer: request control, note decode, threshold compare, result register.
`default_nettype none

module tdms_player #(
	parameter int NOTE_DEPTH = 64,
	localparam int AW = $clog2(NOTE_DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [tdms_pkg::RATE_W-1:0] tick_rate,
	tdms_req_if.sink                         req,
	tdms_rsp_if.source                       rsp,
	output logic                             mem_we,
	output logic      [AW-1:0]               mem_waddr,
	output logic      [tdms_pkg::NOTE_W-1:0] mem_wdata,
	output logic      [AW-1:0]               mem_raddr,
	input  wire logic [tdms_pkg::NOTE_W-1:0] mem_rdata
);
	import tdms_pkg::*;

	seq_state_t state_q, state_d;

	logic accept;
	logic fin_go;

	// Latched request fields
	logic       req_type_q;
	logic       en_q;
	logic [5:0] first_q;
	logic [5:0] last_q;

	// Playback state
	logic               playing_q;
	logic [IDX_W-1:0]   note_index_q;
	logic [COUNT_W-1:0] tick_count_q;

	// Pipeline registers
	logic [BR_W-1:0]     br_s1;
	logic [LHS_W-1:0]    lhs_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic [RHS_W-1:0]    rhs_s2;
	logic [LHS_W-1:0]    lhs_s2;
	logic [PERIOD_W-1:0] period_s2;

	// Result register
	logic                out_valid_q;
	logic                tone_write_q;
	logic [PERIOD_W-1:0] period_q;
	logic                playing_out_q;

	// Decode of the fetched entry
	digits_t    pitch_dg;
	digits_t    dur_dg;
	logic [1:0] octave;
	logic [2:0] step;
	logic [2:0] beat;

	// Commit values
	logic                fin_wr;
	logic [PERIOD_W-1:0] fin_period;
	logic                fin_playing;
	logic [IDX_W-1:0]    fin_idx;
	logic [COUNT_W-1:0]  fin_count;

	// Index wrap modulo the store depth, constant table
	logic [AW-1:0] wrap_tab [IDX_SPAN];
	for (genvar gi = 0; gi < IDX_SPAN; gi++) begin : g_wrap
		assign wrap_tab[gi] = AW'(gi % NOTE_DEPTH);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req.valid) state_d = S_READ;
			S_READ:  state_d = S_MUL;
			S_MUL:   state_d = S_FIN;
			S_FIN:   if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		req.ready = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			S_IDLE:  req.ready = 1'b1;
			S_FIN:   fin_go = !out_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				fin_go    = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	// Store access: load writes at acceptance, ticks read the current note
	assign mem_we    = accept && (req.req_type == REQ_LOAD);
	assign mem_waddr = wrap_tab[{1'b0, req.note_addr}];
	assign mem_wdata = {req.duration_code, req.pitch_code};
	assign mem_raddr = wrap_tab[note_index_q];

	// Decode pitch and duration digits, clamp out-of-range values
	always_comb begin
		pitch_dg = split_digits(mem_rdata[7:0]);
		dur_dg   = split_digits(mem_rdata[15:8]);
		octave   = (pitch_dg.tens > 5'd2) ? 2'd2 : pitch_dg.tens[1:0];
		step     = (pitch_dg.units > 4'd7) ? 3'd7 : pitch_dg.units[2:0];
		beat     = (dur_dg.tens > 5'd6) ? 3'd6 : dur_dg.tens[2:0];
	end

	// Commit decision for the item in flight
	always_comb begin
		fin_wr      = 1'b0;
		fin_period  = SILENT_PERIOD;
		fin_playing = playing_q;
		fin_idx     = note_index_q;
		fin_count   = tick_count_q;
		if (req_type_q == REQ_TICK) begin
			if (!playing_q) begin
				if (en_q) begin
					fin_playing = 1'b1;
					fin_idx     = {1'b0, first_q};
					fin_count   = '0;
				end
			end else if (en_q) begin
				if (lhs_s2 > LHS_W'(rhs_s2)) begin
					fin_wr     = 1'b1;
					fin_period = period_s2;
					fin_idx    = note_index_q + IDX_W'(1);
					fin_count  = '0;
				end else if (tick_count_q != COUNT_MAX) begin
					fin_count = tick_count_q + COUNT_W'(1);
				end
				// stop once past the inclusive end
				if (fin_idx > {1'b0, last_q}) begin
					fin_playing = 1'b0;
					fin_wr      = 1'b1;
					fin_period  = SILENT_PERIOD;
				end
			end else begin
				fin_playing = 1'b0;
				fin_wr      = 1'b1;
				fin_period  = SILENT_PERIOD;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			playing_q    <= 1'b0;
			note_index_q <= '0;
			tick_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_go) begin
				playing_q    <= fin_playing;
				note_index_q <= fin_idx;
				tick_count_q <= fin_count;
				out_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold request fields, run the multiply stages, load the result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			en_q       <= req.play_enable;
			first_q    <= req.first_note;
			last_q     <= req.last_note;
		end
		if (state_q == S_READ) begin
			br_s1     <= BR_W'(BEAT_MS[beat]) * BR_W'(dur_dg.units);
			lhs_s1    <= LHS_W'(tick_count_q) * MS_PER_S;
			period_s1 <= PERIOD_TAB[{octave, step}];
		end
		if (state_q == S_MUL) begin
			rhs_s2    <= RHS_W'(br_s1) * RHS_W'(tick_rate);
			lhs_s2    <= lhs_s1;
			period_s2 <= period_s1;
		end
		if (fin_go) begin
			tone_write_q  <= fin_wr;
			period_q      <= fin_wr ? fin_period : '0;
			playing_out_q <= fin_playing;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.tone_write    = tone_write_q;
	assign rsp.timer_period  = period_q;
	assign rsp.timer_compare = period_q[PERIOD_W-1:1];
	assign rsp.playing       = playing_out_q;

endmodule

`default_nettype wire

FILE: design/tick_driven_melody_sequencer.sv
// Top level of the tick-driven buzzer melody sequencer.
//
// Load requests write a note entry (pitch byte low, duration byte high) into an
// on-chip note store; tick requests step playback and reprogram the tone timer
// when a note's length is reached or playback stops. Every request, load or
// tick, gives exactly one result. The note store is read at the current note
// index in the cycle a request is accepted. The result register loads after a
// decode stage (tick count times 1000, beat length times repeat), a multiply
// by the tick rate, and a compare-and-commit step. One request is in flight
// at a time, so a new request is not accepted before the previous one is
// through: the next is accepted in the cycle after the previous result is
// registered, while that result may still wait for the consumer. A waiting
// result stalls the commit cycle of the next request. The note store has no
// reset: a tick that plays an entry never loaded yields undefined tone values.
// Write the tick rate only while no request is in flight.
`default_nettype none

module tick_driven_melody_sequencer #(
	parameter int NOTE_DEPTH = tdms_pkg::NOTE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tdms_pkg::RATE_W-1:0] cfg_wdata,
	tdms_req_if.sink                         req,
	tdms_rsp_if.source                       rsp
);
	import tdms_pkg::*;

	localparam int AW = $clog2(NOTE_DEPTH);

	logic [RATE_W-1:0] tick_rate_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [NOTE_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [NOTE_W-1:0] mem_rdata;

	// Tick rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RST;
		end else if (cfg_we) begin
			tick_rate_q <= cfg_wdata;
		end
	end

	tdms_player #(
		.NOTE_DEPTH(NOTE_DEPTH)
	) u_player (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_rate (tick_rate_q),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tdms_note_mem #(
		.NOTE_DEPTH(NOTE_DEPTH)
	) u_note_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
